FILE: design/ppi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppi_pkg;

  localparam int unsigned VW = 32;

  typedef logic signed [VW-1:0] val_t;

  typedef struct packed {
    val_t pos_x;
    val_t pos_y;
    val_t heading;
    val_t vel_forward;
    val_t vel_lateral;
    val_t turn_rate;
  } ppi_in_t;

  typedef struct packed {
    val_t new_x;
    val_t new_y;
    val_t new_heading;
    logic saturated;
  } ppi_out_t;

  // pi/2 in unsigned Q1.30 and its scaled reciprocal for the quadrant estimate
  localparam logic [30:0] HALF_PI = 31'd1686629713;
  localparam logic [15:0] RECIP   = 16'((64'd1 << 46) / 64'd1686629713);

  localparam val_t ONE_Q30      = 32'sd1073741824;
  localparam val_t HALF_Q30     = 32'sd536870912;
  localparam val_t INV6_Q30     = 32'sd178956971;
  localparam val_t INV120_Q30   = 32'sd8947849;
  localparam val_t INV5040_Q30  = 32'sd213044;
  localparam val_t INV24_Q30    = 32'sd44739243;
  localparam val_t INV720_Q30   = 32'sd1491308;
  localparam val_t INV40320_Q30 = 32'sd26631;

  localparam logic [15:0] STEP_RESET = 16'd655;

  localparam logic [2:0] ADDR_STEP = 3'd0;

  // shift right with rounding half away from zero
  function automatic logic signed [63:0] round_shift(input logic signed [63:0] p,
                                                     input int unsigned sh);
    logic [63:0] mag;
    logic [63:0] res;
    mag = p[63] ? 64'(-p) : 64'(p);
    res = (mag + (64'd1 << (sh - 1))) >> sh;
    return p[63] ? -$signed(res) : $signed(res);
  endfunction

  function automatic val_t mul_q30(input val_t a, input val_t b);
    logic signed [63:0] r;
    r = round_shift(64'(a) * 64'(b), 30);
    return r[VW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: design/ppi_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
module ppi_reduce (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            adv_i,
  input  wire logic            valid_i,
  input  wire ppi_pkg::ppi_in_t item_i,
  output logic                 valid_o,
  output ppi_pkg::ppi_in_t     item_o,
  output ppi_pkg::val_t        r_o,
  output logic [1:0]           quad_o
);

  logic [2:0] v_q;
  ppi_pkg::ppi_in_t it1_q, it2_q, it3_q;
  logic        neg1_q, neg2_q;
  logic [31:0] m1_q;
  logic [15:0] qe1_q, q2_q;
  logic [31:0] rem2_q;
  ppi_pkg::val_t r3_q;
  logic [1:0]  quad3_q;

  logic [31:0] m_d;
  logic [47:0] prod_d;
  logic [46:0] diff_d;
  logic [15:0] qa, qb;
  logic [31:0] ra;
  logic signed [32:0] rs;
  logic signed [32:0] rsg;
  logic [15:0] qneg;

  always_comb begin
    m_d    = item_i.heading[31] ? 32'(-item_i.heading) : 32'(item_i.heading);
    prod_d = 48'(m_d) * 48'(ppi_pkg::RECIP);
    diff_d = {1'b0, m1_q, 14'd0} - (47'(qe1_q) * 47'(ppi_pkg::HALF_PI));
  end

  // fix the estimate, then round to nearest
  always_comb begin
    qa = q2_q;
    ra = rem2_q;
    if (rem2_q >= 32'(ppi_pkg::HALF_PI)) begin
      qa = q2_q + 16'd1;
      ra = rem2_q - 32'(ppi_pkg::HALF_PI);
    end
    qb = qa;
    rs = $signed({1'b0, ra});
    if ({ra, 1'b0} >= 33'(ppi_pkg::HALF_PI)) begin
      qb = qa + 16'd1;
      rs = $signed({1'b0, ra}) - $signed({2'b00, ppi_pkg::HALF_PI});
    end
    rsg  = neg2_q ? -rs : rs;
    qneg = -qb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it1_q   <= item_i;
      neg1_q  <= item_i.heading[31];
      m1_q    <= m_d;
      qe1_q   <= prod_d[47:32];
      it2_q   <= it1_q;
      neg2_q  <= neg1_q;
      q2_q    <= qe1_q;
      rem2_q  <= diff_d[31:0];
      it3_q   <= it2_q;
      r3_q    <= rsg[31:0];
      quad3_q <= neg2_q ? qneg[1:0] : qb[1:0];
    end
  end

  assign valid_o = v_q[2];
  assign item_o  = it3_q;
  assign r_o     = r3_q;
  assign quad_o  = quad3_q;

endmodule
`default_nettype wire

FILE: design/ppi_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
module ppi_sincos (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             valid_i,
  input  wire ppi_pkg::ppi_in_t item_i,
  input  wire ppi_pkg::val_t    r_i,
  input  wire logic [1:0]       quad_i,
  output logic                  valid_o,
  output ppi_pkg::ppi_in_t      item_o,
  output ppi_pkg::val_t         sn_o,
  output ppi_pkg::val_t         cs_o,
  output logic [1:0]            quad_o
);

  logic [4:0] v_q;
  ppi_pkg::ppi_in_t it_q [5];
  logic [1:0]       qd_q [5];
  ppi_pkg::val_t    r_q  [4];
  ppi_pkg::val_t    u_q  [4];
  ppi_pkg::val_t ts1_q, tc1_q, ts2_q, tc2_q, ts3_q, tc3_q, sn_q, cs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  // horner chains for sine and cosine, one product per stage
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it_q[0] <= item_i;
      qd_q[0] <= quad_i;
      r_q[0]  <= r_i;
      u_q[0]  <= ppi_pkg::mul_q30(r_i, r_i);
      for (int k = 1; k < 5; k++) begin
        it_q[k] <= it_q[k-1];
        qd_q[k] <= qd_q[k-1];
      end
      for (int k = 1; k < 4; k++) begin
        r_q[k] <= r_q[k-1];
        u_q[k] <= u_q[k-1];
      end
      ts1_q <= ppi_pkg::INV120_Q30 - ppi_pkg::mul_q30(u_q[0], ppi_pkg::INV5040_Q30);
      tc1_q <= ppi_pkg::INV720_Q30 - ppi_pkg::mul_q30(u_q[0], ppi_pkg::INV40320_Q30);
      ts2_q <= ppi_pkg::INV6_Q30 - ppi_pkg::mul_q30(u_q[1], ts1_q);
      tc2_q <= ppi_pkg::INV24_Q30 - ppi_pkg::mul_q30(u_q[1], tc1_q);
      ts3_q <= ppi_pkg::ONE_Q30 - ppi_pkg::mul_q30(u_q[2], ts2_q);
      tc3_q <= ppi_pkg::HALF_Q30 - ppi_pkg::mul_q30(u_q[2], tc2_q);
      sn_q  <= ppi_pkg::mul_q30(r_q[3], ts3_q);
      cs_q  <= ppi_pkg::ONE_Q30 - ppi_pkg::mul_q30(u_q[3], tc3_q);
    end
  end

  assign valid_o = v_q[4];
  assign item_o  = it_q[4];
  assign sn_o    = sn_q;
  assign cs_o    = cs_q;
  assign quad_o  = qd_q[4];

endmodule
`default_nettype wire

FILE: design/ppi_update.sv
`timescale 1ns / 1ps
`default_nettype none
module ppi_update (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             valid_i,
  input  wire ppi_pkg::ppi_in_t item_i,
  input  wire ppi_pkg::val_t    sn_i,
  input  wire ppi_pkg::val_t    cs_i,
  input  wire logic [1:0]       quad_i,
  input  wire logic [15:0]      dt_i,
  output logic                  valid_o,
  output ppi_pkg::ppi_out_t     out_o
);

  localparam logic signed [35:0] TOP = 36'sd2147483647;
  localparam logic signed [35:0] BOT = -36'sd2147483648;

  logic [3:0] v_q;
  ppi_pkg::ppi_in_t it1_q, it2_q, it3_q;
  logic signed [32:0] p_fc_q, p_ls_q, p_fs_q, p_lc_q;
  logic signed [33:0] dx_q, dy_q;
  logic signed [34:0] ix_q, iy_q, ih_q;
  ppi_pkg::ppi_out_t out_q;

  ppi_pkg::val_t s, c;
  logic signed [63:0] w_fc, w_ls, w_fs, w_lc, w_x, w_y, w_h;
  logic signed [16:0] dts;
  logic signed [35:0] sx, sy, sh;
  ppi_pkg::ppi_out_t out_d;

  always_comb begin
    case (quad_i)
      2'd1:    begin s = cs_i;  c = -sn_i; end
      2'd2:    begin s = -sn_i; c = -cs_i; end
      2'd3:    begin s = -cs_i; c = sn_i;  end
      default: begin s = sn_i;  c = cs_i;  end
    endcase
    w_fc = ppi_pkg::round_shift(64'(item_i.vel_forward) * 64'(c), 30);
    w_ls = ppi_pkg::round_shift(64'(item_i.vel_lateral) * 64'(s), 30);
    w_fs = ppi_pkg::round_shift(64'(item_i.vel_forward) * 64'(s), 30);
    w_lc = ppi_pkg::round_shift(64'(item_i.vel_lateral) * 64'(c), 30);
    dts  = $signed({1'b0, dt_i});
    w_x  = ppi_pkg::round_shift(64'(dx_q) * 64'(dts), 16);
    w_y  = ppi_pkg::round_shift(64'(dy_q) * 64'(dts), 16);
    w_h  = ppi_pkg::round_shift(64'(it2_q.turn_rate) * 64'(dts), 16);
  end

  // add the increments and clamp to the signed range
  always_comb begin
    sx = 36'(it3_q.pos_x) + 36'(ix_q);
    sy = 36'(it3_q.pos_y) + 36'(iy_q);
    sh = 36'(it3_q.heading) + 36'(ih_q);
    out_d.saturated = 1'b0;
    out_d.new_x = sx[31:0];
    out_d.new_y = sy[31:0];
    out_d.new_heading = sh[31:0];
    if (sx > TOP) begin
      out_d.new_x = TOP[31:0];
      out_d.saturated = 1'b1;
    end else if (sx < BOT) begin
      out_d.new_x = BOT[31:0];
      out_d.saturated = 1'b1;
    end
    if (sy > TOP) begin
      out_d.new_y = TOP[31:0];
      out_d.saturated = 1'b1;
    end else if (sy < BOT) begin
      out_d.new_y = BOT[31:0];
      out_d.saturated = 1'b1;
    end
    if (sh > TOP) begin
      out_d.new_heading = TOP[31:0];
      out_d.saturated = 1'b1;
    end else if (sh < BOT) begin
      out_d.new_heading = BOT[31:0];
      out_d.saturated = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      it1_q  <= item_i;
      p_fc_q <= w_fc[32:0];
      p_ls_q <= w_ls[32:0];
      p_fs_q <= w_fs[32:0];
      p_lc_q <= w_lc[32:0];
      it2_q  <= it1_q;
      dx_q   <= 34'(p_fc_q) - 34'(p_ls_q);
      dy_q   <= 34'(p_fs_q) + 34'(p_lc_q);
      it3_q  <= it2_q;
      ix_q   <= w_x[34:0];
      iy_q   <= w_y[34:0];
      ih_q   <= w_h[34:0];
      out_q  <= out_d;
    end
  end

  assign valid_o = v_q[3];
  assign out_o   = out_q;

endmodule
`default_nettype wire

FILE: design/planar_pose_integrator_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
// one forward euler step of a planar robot pose per beat
// input channel: in_valid_i / in_stall_o with in_data_i (pose and body velocities)
// output channel: out_valid_o / out_stall_i with out_data_o (new pose, saturated flag)
// a beat moves on an edge where valid is high and stall is low
// step_time sits at apb byte address 0, reset value 655 (about 10 ms)
// a beat passes the quadrant reduction, then the sine and
// cosine polynomials, then rotation, step product and clamping
// throughput is one beat per cycle unless stalled, set by a multiplier per register
// when the receiver stalls with a result waiting, the whole pipe holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated
// reset clears all valid bits and restores step_time
module planar_pose_integrator_sincos (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire ppi_pkg::ppi_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ppi_pkg::ppi_out_t      out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [15:0] step_q;
  logic        adv;

  logic             red_valid;
  ppi_pkg::ppi_in_t red_item;
  ppi_pkg::val_t    red_r;
  logic [1:0]       red_quad;

  logic             sc_valid;
  ppi_pkg::ppi_in_t sc_item;
  ppi_pkg::val_t    sc_sn, sc_cs;
  logic [1:0]       sc_quad;

  // the pipe only freezes while a finished result is held back
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // apb register file: step_time only, always ready
  assign pready = 1'b1;
  assign prdata = (paddr == ppi_pkg::ADDR_STEP) ? {16'd0, step_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ppi_pkg::STEP_RESET;
    end else if (psel && penable && pwrite && paddr == ppi_pkg::ADDR_STEP) begin
      step_q <= pwdata[15:0];
    end
  end

  // heading reduced to r in [-pi/4, pi/4] and a quadrant
  ppi_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .valid_o (red_valid),
    .item_o  (red_item),
    .r_o     (red_r),
    .quad_o  (red_quad)
  );

  // taylor polynomials for sine and cosine of r
  ppi_sincos u_sincos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (red_valid),
    .item_i  (red_item),
    .r_i     (red_r),
    .quad_i  (red_quad),
    .valid_o (sc_valid),
    .item_o  (sc_item),
    .sn_o    (sc_sn),
    .cs_o    (sc_cs),
    .quad_o  (sc_quad)
  );

  // quadrant fix-up, world-frame rotation, integration and clamping
  ppi_update u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (sc_valid),
    .item_i  (sc_item),
    .sn_i    (sc_sn),
    .cs_i    (sc_cs),
    .quad_i  (sc_quad),
    .dt_i    (step_q),
    .valid_o (out_valid_o),
    .out_o   (out_data_o)
  );

endmodule
`default_nettype wire
